// ===== rtl/core/hbos_pkg.sv =====
// shared types and constants for the hashed block owner select block
// no dependencies; imported by every module under rtl/core
package hbos_pkg;

    localparam int DIV_W      = 9;
    localparam int HASH_W     = 64;
    localparam int DIV_STEPS  = HASH_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int CFG_DATA_W = 16;
    localparam logic [31:0] HASH_GOLDEN = 32'h9e3779b9;

    typedef enum logic [1:0] {
        CMD_HASH   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_DIRECT = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_SERVER_COUNT = 1'b0,
        CFG_MY_RANK      = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] index_value;
        logic               last_index;
        logic [63:0]        linear_block;
        logic [7:0]         table_slot;
        logic [15:0]        table_rank;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  server_slot;
        logic [15:0] server_rank;
        logic        is_mine;
    } t_out_item;

    typedef struct packed {
        logic fold;       // fold index into seed
        logic start_div;  // load dividend, clear remainder
        logic use_direct; // dividend from linear_block instead of new seed
        logic write_tbl;  // rank table write
        logic div_step;   // one restoring remainder step
        logic read_tbl;   // registered table read at remainder
        logic load_out;   // capture result into output register
    } t_dp_cmd;

endpackage

// ===== rtl/core/hbos_ctrl.sv =====
// controller for hashed block owner select: sequences fold, remainder and lookup
// depends on hbos_pkg
module hbos_ctrl
    import hbos_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_cmd     i_cmd,
    input  logic     i_last_index,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_dp_cmd  o_dp_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_LOAD
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             in_acc;
    logic             out_free;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_dp_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_cmd)
                        CMD_HASH: begin
                            o_dp_cmd.fold = 1'b1;
                            if (i_last_index) begin
                                o_dp_cmd.start_div = 1'b1;
                                n_cnt   = '0;
                                n_state = S_DIV;
                            end
                        end
                        CMD_DIRECT: begin
                            o_dp_cmd.start_div  = 1'b1;
                            o_dp_cmd.use_direct = 1'b1;
                            n_cnt   = '0;
                            n_state = S_DIV;
                        end
                        CMD_WRITE: o_dp_cmd.write_tbl = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                o_dp_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_dp_cmd.read_tbl = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    o_dp_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_LOAD))
        else $error("result raised outside load state");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == CNT_W'(DIV_STEPS - 1)) |=> (r_state == S_READ))
        else $error("remainder did not finish after full step count");

    a_last_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_cmd == CMD_HASH && i_last_index) |=> (r_state == S_DIV && r_cnt == '0))
        else $error("last index did not start remainder");

    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("output overwritten while pending");

endmodule

// ===== rtl/core/hbos_dp.sv =====
// datapath for hashed block owner select: seed, config, bit-serial remainder,
// rank table memory and output register; depends on hbos_pkg
module hbos_dp
    import hbos_pkg::*;
#(
    parameter int MAX_SERVERS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_dp_cmd,
    input  t_in_item              i_in_data,
    input  logic                  i_cfg_we,
    input  t_cfg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_out_item             o_out_data
);

    localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

    logic [DIV_W-1:0]  r_server_count;
    logic [15:0]       r_my_rank;
    logic [HASH_W-1:0] r_seed, n_seed;
    logic [HASH_W-1:0] r_dividend;
    logic [DIV_W-1:0]  r_rem;
    logic [15:0]       r_rd_rank;
    t_out_item         r_out;
    logic [15:0]       rank_mem [MAX_SERVERS];

    logic [31:0]       term;
    logic [DIV_W-1:0]  eff_div;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    trial_sub;

    assign term   = i_in_data.index_value + HASH_GOLDEN;
    assign n_seed = r_seed ^ ({32'b0, term} + (r_seed << 6) + (r_seed >> 2));

    // zero divisor acts as one, oversize divisor clamps to table depth
    always_comb begin
        if (r_server_count == '0) begin
            eff_div = DIV_W'(1);
        end else if (32'(r_server_count) > MAX_SERVERS) begin
            eff_div = DIV_W'(MAX_SERVERS);
        end else begin
            eff_div = r_server_count;
        end
    end

    // restoring remainder: shift in one dividend bit per step
    assign trial     = {r_rem, r_dividend[HASH_W-1]};
    assign trial_sub = trial - {1'b0, eff_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_count <= DIV_W'(1);
            r_my_rank      <= '0;
            r_seed         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SERVER_COUNT: r_server_count <= i_cfg_data[DIV_W-1:0];
                    CFG_MY_RANK:      r_my_rank      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_dp_cmd.start_div && !i_dp_cmd.use_direct) begin
                r_seed <= '0;
            end else if (i_dp_cmd.fold) begin
                r_seed <= n_seed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.start_div) begin
            r_dividend <= i_dp_cmd.use_direct ? i_in_data.linear_block : n_seed;
            r_rem      <= '0;
        end else if (i_dp_cmd.div_step) begin
            r_dividend <= {r_dividend[HASH_W-2:0], 1'b0};
            r_rem      <= (trial >= {1'b0, eff_div}) ? trial_sub[DIV_W-1:0]
                                                     : trial[DIV_W-1:0];
        end
        if (i_dp_cmd.load_out) begin
            r_out.server_slot <= r_rem[7:0];
            r_out.server_rank <= r_rd_rank;
            r_out.is_mine     <= (r_rd_rank == r_my_rank);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.write_tbl && (32'(i_in_data.table_slot) < MAX_SERVERS)) begin
            rank_mem[AW'(i_in_data.table_slot)] <= i_in_data.table_rank;
        end
        if (i_dp_cmd.read_tbl) begin
            r_rd_rank <= rank_mem[AW'(r_rem)];
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== rtl/core/hashed_block_owner_select.sv =====
// top level of hashed block owner select: controller plus datapath
// depends on hbos_pkg, hbos_ctrl, hbos_dp
//
// Folds block-id indices into a 64-bit golden-ratio mixing seed and maps the hash
// (or a direct block number) to a server slot, its rank from a rank table
// and an ownership flag. A hash index that is not the last, a rank-table
// write or an unused command is done when it is accepted. A last index or a direct block
// number holds off the next transaction while it runs through these steps: accept,
// the bit-serial restoring remainder unit over all 64 hash bits (one hash bit per
// cycle), the registered rank table read and the load of the output register.
// The load waits while an earlier result is still stalled in the output register.
// The output register holds a result while the next transactions come in.
// Rank table entries must be written before they are looked up.
module hashed_block_owner_select
    import hbos_pkg::*;
#(
    parameter int MAX_SERVERS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  t_cfg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd dp_cmd;

    hbos_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_cmd        (i_in_data.cmd),
        .i_last_index (i_in_data.last_index),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_dp_cmd     (dp_cmd)
    );

    hbos_dp #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dp_cmd    (dp_cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule
